@@ design/shabsh_pkg.sv @@
// shared types, constants and round functions for the sha-256 byte stream hasher
package shabsh_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned BUF_DEPTH = 64;
  localparam int unsigned BUF_AW   = 6;
  localparam int unsigned CV_DEPTH = 8;
  localparam int unsigned CV_AW    = 3;
  localparam int unsigned LEN_W    = 64;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned SCHED_W  = 512;

  localparam logic [BYTE_W-1:0] PAD_MARK  = 8'h80;
  localparam logic [LEN_W-1:0]  LEN_STEP  = 64'd8;
  localparam logic [BUF_AW-1:0] PAD_LIMIT = 6'd56;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_PAD1,
    BLK_PAD2
  } blk_e;

  function automatic word_t iv_word(input logic [CV_AW-1:0] idx);
    word_t w;
    case (idx)
      3'd0: w = 32'h6a09e667;
      3'd1: w = 32'hbb67ae85;
      3'd2: w = 32'h3c6ef372;
      3'd3: w = 32'ha54ff53a;
      3'd4: w = 32'h510e527f;
      3'd5: w = 32'h9b05688c;
      3'd6: w = 32'h1f83d9ab;
      default: w = 32'h5be0cd19;
    endcase
    return w;
  endfunction

  function automatic word_t round_k(input logic [5:0] r);
    word_t k;
    case (r)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t big_sig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ design/sha256_byte_stream_hasher.sv @@
// sha-256 over a byte stream: block buffer ram, chaining value ram and round unit
//
//   channel  handshake                  payload                                       dir
//   in       in_valid_i / in_stall_o    data_byte_i, has_byte_i, is_last_i            in
//   out      out_valid_o / out_stall_i  digest_word_o, word_index_o, last_word_o      out
//
// a byte item that does not fill the block or end the message does not stall the input
// a full block stalls the input through the load, round and write-back states
// the end of a message runs one or two padding blocks, then reads each digest word
// out of the chaining ram through the read and load states; a stalled output holds the next read
// reset and each finished digest return the chaining words to the initial values

module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam int unsigned BUF_AW = shabsh_pkg::BUF_AW;
  localparam int unsigned CV_AW  = shabsh_pkg::CV_AW;
  localparam int unsigned CNT_W  = shabsh_pkg::CNT_W;

  shabsh_pkg::state_e state_q, state_d;
  shabsh_pkg::blk_e   blk_q, blk_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [BUF_AW-1:0]  idx_q;
  logic [BUF_AW-1:0]  fill_q, fill_d;
  logic [shabsh_pkg::LEN_W-1:0] len_q, len_d;
  logic               pend_q, pend_d;
  logic [shabsh_pkg::CV_DEPTH-1:0] cv_vld_q, cv_vld_d;

  logic [shabsh_pkg::SCHED_W-1:0] w_q;
  shabsh_pkg::word_t  wk_q [shabsh_pkg::CV_DEPTH];

  logic               out_valid_q;
  shabsh_pkg::word_t  out_word_q;
  logic [CV_AW-1:0]   out_idx_q;
  logic               out_last_q;

  logic               in_acc;
  logic               buf_re;
  shabsh_pkg::byte_t  buf_rdata;
  logic               cv_re;
  logic               cv_we;
  shabsh_pkg::word_t  cv_rdata;
  shabsh_pkg::word_t  cv_rd;
  shabsh_pkg::word_t  cv_wdata;

  logic               ld_shift;
  logic               wk_fill;
  logic               rnd_en;
  logic               fin_shift;
  logic               out_load;

  shabsh_pkg::byte_t  ld_byte;
  shabsh_pkg::byte_t  len_byte;
  shabsh_pkg::word_t  sched_new;
  shabsh_pkg::word_t  t1;
  shabsh_pkg::word_t  t2;

  assign in_stall_o = (state_q != shabsh_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & ~in_stall_o;

  shabsh_ram #(
    .WIDTH(shabsh_pkg::BYTE_W),
    .DEPTH(shabsh_pkg::BUF_DEPTH)
  ) u_buf_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc & has_byte_i),
    .waddr_i(fill_q),
    .wdata_i(data_byte_i),
    .re_i   (buf_re),
    .raddr_i(cnt_q[BUF_AW-1:0]),
    .rdata_o(buf_rdata)
  );

  shabsh_ram #(
    .WIDTH(shabsh_pkg::WORD_W),
    .DEPTH(shabsh_pkg::CV_DEPTH)
  ) u_cv_ram (
    .clk_i  (clk_i),
    .we_i   (cv_we),
    .waddr_i(idx_q[CV_AW-1:0]),
    .wdata_i(cv_wdata),
    .re_i   (cv_re),
    .raddr_i(cnt_q[CV_AW-1:0]),
    .rdata_o(cv_rdata)
  );

  // unwritten chaining entries read as the initial values
  assign cv_rd    = cv_vld_q[idx_q[CV_AW-1:0]] ? cv_rdata
                                                : shabsh_pkg::iv_word(idx_q[CV_AW-1:0]);
  assign cv_wdata = cv_rd + wk_q[0];

  // padding bytes replace buffer contents past the message
  assign len_byte = len_q[{~idx_q[2:0], 3'b000} +: 8];

  always_comb begin
    case (blk_q)
      shabsh_pkg::BLK_DATA: begin
        ld_byte = buf_rdata;
      end
      shabsh_pkg::BLK_PAD1: begin
        if (idx_q < fill_q) begin
          ld_byte = buf_rdata;
        end else if (idx_q == fill_q) begin
          ld_byte = shabsh_pkg::PAD_MARK;
        end else if ((idx_q >= shabsh_pkg::PAD_LIMIT) && (fill_q < shabsh_pkg::PAD_LIMIT)) begin
          ld_byte = len_byte;
        end else begin
          ld_byte = '0;
        end
      end
      shabsh_pkg::BLK_PAD2: begin
        ld_byte = (idx_q >= shabsh_pkg::PAD_LIMIT) ? len_byte : '0;
      end
      default: begin
        ld_byte = '0;
      end
    endcase
  end

  // message schedule and round datapath
  assign sched_new = shabsh_pkg::small_sig1(w_q[63:32]) + w_q[223:192]
                   + shabsh_pkg::small_sig0(w_q[479:448]) + w_q[511:480];

  assign t1 = wk_q[7] + shabsh_pkg::big_sig1(wk_q[4])
            + ((wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]))
            + shabsh_pkg::round_k(cnt_q[5:0]) + w_q[511:480];
  assign t2 = shabsh_pkg::big_sig0(wk_q[0])
            + ((wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]));

  always_comb begin
    state_d   = state_q;
    blk_d     = blk_q;
    cnt_d     = cnt_q;
    fill_d    = fill_q;
    len_d     = len_q;
    pend_d    = pend_q;
    cv_vld_d  = cv_vld_q;
    buf_re    = 1'b0;
    cv_re     = 1'b0;
    cv_we     = 1'b0;
    ld_shift  = 1'b0;
    wk_fill   = 1'b0;
    rnd_en    = 1'b0;
    fin_shift = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      shabsh_pkg::ST_IDLE: begin
        if (in_acc) begin
          pend_d = is_last_i;
          if (has_byte_i) begin
            fill_d = fill_q + 6'd1;
            len_d  = len_q + shabsh_pkg::LEN_STEP;
          end
          if (has_byte_i && (&fill_q)) begin
            blk_d   = shabsh_pkg::BLK_DATA;
            state_d = shabsh_pkg::ST_LOAD;
            cnt_d   = '0;
          end else if (is_last_i) begin
            blk_d   = shabsh_pkg::BLK_PAD1;
            state_d = shabsh_pkg::ST_LOAD;
            cnt_d   = '0;
          end
        end
      end
      shabsh_pkg::ST_LOAD: begin
        buf_re   = ~cnt_q[CNT_W-1];
        cv_re    = (cnt_q < 7'd8);
        ld_shift = (cnt_q != '0);
        wk_fill  = (cnt_q != '0) && (cnt_q <= 7'd8);
        if (cnt_q[CNT_W-1]) begin
          state_d = shabsh_pkg::ST_ROUND;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      shabsh_pkg::ST_ROUND: begin
        rnd_en = 1'b1;
        if (&cnt_q[5:0]) begin
          state_d = shabsh_pkg::ST_FIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 7'd1;
        end
      end
      shabsh_pkg::ST_FIN: begin
        cv_re     = (cnt_q < 7'd8);
        cv_we     = (cnt_q != '0);
        fin_shift = (cnt_q != '0);
        if (cnt_q != '0) begin
          cv_vld_d[idx_q[CV_AW-1:0]] = 1'b1;
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          cnt_d = '0;
          case (blk_q)
            shabsh_pkg::BLK_DATA: begin
              if (pend_q) begin
                blk_d   = shabsh_pkg::BLK_PAD1;
                state_d = shabsh_pkg::ST_LOAD;
              end else begin
                state_d = shabsh_pkg::ST_IDLE;
              end
            end
            shabsh_pkg::BLK_PAD1: begin
              if (fill_q >= shabsh_pkg::PAD_LIMIT) begin
                blk_d   = shabsh_pkg::BLK_PAD2;
                state_d = shabsh_pkg::ST_LOAD;
              end else begin
                state_d = shabsh_pkg::ST_EMIT_RD;
              end
            end
            default: begin
              state_d = shabsh_pkg::ST_EMIT_RD;
            end
          endcase
        end
      end
      shabsh_pkg::ST_EMIT_RD: begin
        if (!out_valid_q || !out_stall_i) begin
          cv_re   = 1'b1;
          state_d = shabsh_pkg::ST_EMIT_LD;
        end
      end
      shabsh_pkg::ST_EMIT_LD: begin
        out_load = 1'b1;
        if (&cnt_q[CV_AW-1:0]) begin
          state_d  = shabsh_pkg::ST_IDLE;
          cnt_d    = '0;
          fill_d   = '0;
          len_d    = '0;
          pend_d   = 1'b0;
          cv_vld_d = '0;
        end else begin
          state_d = shabsh_pkg::ST_EMIT_RD;
          cnt_d   = cnt_q + 7'd1;
        end
      end
      default: begin
        state_d = shabsh_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shabsh_pkg::ST_IDLE;
      blk_q       <= shabsh_pkg::BLK_DATA;
      cnt_q       <= '0;
      idx_q       <= '0;
      fill_q      <= '0;
      len_q       <= '0;
      pend_q      <= 1'b0;
      cv_vld_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      blk_q    <= blk_d;
      cnt_q    <= cnt_d;
      idx_q    <= cnt_q[BUF_AW-1:0];
      fill_q   <= fill_d;
      len_q    <= len_d;
      pend_q   <= pend_d;
      cv_vld_q <= cv_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_shift) begin
      w_q <= {w_q[shabsh_pkg::SCHED_W-9:0], ld_byte};
    end else if (rnd_en) begin
      w_q <= {w_q[shabsh_pkg::SCHED_W-33:0], sched_new};
    end
    if (wk_fill || fin_shift) begin
      for (int i = 0; i < 7; i++) begin
        wk_q[i] <= wk_q[i+1];
      end
      wk_q[7] <= cv_rd;
    end else if (rnd_en) begin
      wk_q[0] <= t1 + t2;
      wk_q[1] <= wk_q[0];
      wk_q[2] <= wk_q[1];
      wk_q[3] <= wk_q[2];
      wk_q[4] <= wk_q[3] + t1;
      wk_q[5] <= wk_q[4];
      wk_q[6] <= wk_q[5];
      wk_q[7] <= wk_q[6];
    end
    if (out_load) begin
      out_word_q <= cv_rd;
      out_idx_q  <= idx_q[CV_AW-1:0];
      out_last_q <= &idx_q[CV_AW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = out_last_q;

endmodule

@@ design/shabsh_ram.sv @@
// generic simple dual-port ram with registered read
module shabsh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ bench/tb_sha256_byte_stream_hasher.sv @@
// testbench for the sha-256 byte stream hasher: random messages checked against a digest predictor
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned ITEM_TARGET = 460;
  localparam int unsigned DRAIN_CYCLES = 300;

  localparam logic [8*32-1:0] HASH_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [64*32-1:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       ends_msg;
  } stream_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        has_byte_i = 1'b0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_byte_stream_hasher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .has_byte_i    (has_byte_i),
    .is_last_i     (is_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

  always #5 clk_i = ~clk_i;

  stream_item_t pending_q[$];
  digest_word_t digest_q[$];
  stream_item_t next_item;
  digest_word_t want;

  logic [31:0] chain_words [8];
  logic [7:0]  block_bytes [64];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  int unsigned queued_cnt = 0;
  int unsigned total_items = 1;
  int unsigned taken_cnt = 0;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic hash_restart();
    for (int i = 0; i < 8; i++) chain_words[i] = HASH_INIT[(7 - i)*32 +: 32];
    for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    block_fill = 0;
    msg_bits = '0;
  endtask

  task automatic compress_block();
    logic [31:0] sched [64];
    logic [31:0] work [8];
    logic [31:0] s_lo, s_hi, t1, t2;
    for (int r = 0; r < 16; r++) begin
      sched[r] = {block_bytes[4*r], block_bytes[4*r+1], block_bytes[4*r+2], block_bytes[4*r+3]};
    end
    for (int r = 16; r < 64; r++) begin
      s_lo = rotr(sched[r-15], 7) ^ rotr(sched[r-15], 18) ^ (sched[r-15] >> 3);
      s_hi = rotr(sched[r-2], 17) ^ rotr(sched[r-2], 19) ^ (sched[r-2] >> 10);
      sched[r] = sched[r-16] + s_lo + sched[r-7] + s_hi;
    end
    for (int i = 0; i < 8; i++) work[i] = chain_words[i];
    for (int r = 0; r < 64; r++) begin
      t1 = work[7] + (rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25))
         + ((work[4] & work[5]) ^ (~work[4] & work[6]))
         + ROUND_CONST[(63 - r)*32 +: 32] + sched[r];
      t2 = (rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22))
         + ((work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]));
      work[7] = work[6];
      work[6] = work[5];
      work[5] = work[4];
      work[4] = work[3] + t1;
      work[3] = work[2];
      work[2] = work[1];
      work[1] = work[0];
      work[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_words[i] = chain_words[i] + work[i];
  endtask

  // takes one accepted item and queues the digest words it produces
  task automatic absorb_item(input logic [7:0] data, input logic has_data, input logic ends_msg);
    int unsigned pos;
    digest_word_t dw;
    if (has_data) begin
      block_bytes[block_fill] = data;
      block_fill++;
      msg_bits = msg_bits + 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (ends_msg) begin
      pos = block_fill;
      block_bytes[pos] = PAD_BYTE;
      for (int k = pos + 1; k < 64; k++) block_bytes[k] = 8'h00;
      if (pos >= 56) begin
        compress_block();
        for (int k = 0; k < 64; k++) block_bytes[k] = 8'h00;
      end
      for (int k = 0; k < 8; k++) block_bytes[56 + k] = msg_bits[(7 - k)*8 +: 8];
      compress_block();
      for (int k = 0; k < 8; k++) begin
        dw.word = chain_words[k];
        dw.index = 3'(k);
        dw.final_word = (k == 7);
        digest_q.push_back(dw);
      end
      hash_restart();
    end
  endtask

  task automatic push_item(input logic [7:0] data, input logic has_data, input logic ends_msg);
    stream_item_t it;
    it.data = data;
    it.has_data = has_data;
    it.ends_msg = ends_msg;
    pending_q.push_back(it);
    if (has_data || ends_msg) queued_cnt++;
  endtask

  // mostly short messages, some near the padding and block boundaries
  task automatic push_message();
    int unsigned msg_len;
    int unsigned pick;
    bit end_on_byte;
    pick = $urandom_range(9);
    if (pick <= 5) begin
      msg_len = $urandom_range(10);
    end else if (pick <= 8) begin
      case ($urandom_range(7))
        0: msg_len = 55;
        1: msg_len = 56;
        2: msg_len = 57;
        3: msg_len = 63;
        4: msg_len = 64;
        5: msg_len = 65;
        6: msg_len = 119;
        default: msg_len = 120;
      endcase
    end else begin
      msg_len = $urandom_range(130, 1);
    end
    end_on_byte = (msg_len != 0) && $urandom_range(1);
    for (int i = 0; i < msg_len; i++) begin
      if ($urandom_range(9) == 0) push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, end_on_byte && (i == msg_len - 1));
    end
    if (!end_on_byte) push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int unsigned idle_pct(input bit sender_side);
    if (taken_cnt < total_items / 3) return sender_side ? 32 : 46;
    if (taken_cnt < 2 * total_items / 3) return sender_side ? 46 : 32;
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        absorb_item(data_byte_i, has_byte_i, is_last_i);
        if (has_byte_i || is_last_i) taken_cnt <= taken_cnt + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          next_item = pending_q.pop_front();
          data_byte_i <= next_item.data;
          has_byte_i  <= next_item.has_data;
          is_last_i   <= next_item.ends_msg;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < idle_pct(1'b0));
      if (out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word: expected none, actual %08h index %0d",
                   $time, digest_word_o, word_index_o);
          error_cnt++;
        end else begin
          want = digest_q.pop_front();
          if (digest_word_o !== want.word) begin
            $display("%0t: digest_word mismatch: expected %08h, actual %08h",
                     $time, want.word, digest_word_o);
            error_cnt++;
          end
          if (word_index_o !== want.index) begin
            $display("%0t: word_index mismatch: expected %0d, actual %0d",
                     $time, want.index, word_index_o);
            error_cnt++;
          end
          if (last_word_o !== want.final_word) begin
            $display("%0t: last_word mismatch: expected %0b, actual %0b",
                     $time, want.final_word, last_word_o);
            error_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    hash_restart();
    // idle item, then empty message
    push_item(8'h5a, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    // "abc" with the end mark on the last byte
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    // byte extremes, an idle item inside the message, separate end mark
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    // empty message with a junk data byte, then two one-byte messages
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'h80, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    while (queued_cnt < ITEM_TARGET) push_message();
    total_items = queued_cnt;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0 || in_valid_i || digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_cnt == 0 && digest_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sha256_byte_stream_hasher.f @@
design/shabsh_pkg.sv
design/shabsh_ram.sv
design/sha256_byte_stream_hasher.sv
bench/tb_sha256_byte_stream_hasher.sv
